// File: hw/rtl/fsa_pkg.sv
package fsa_pkg;

	localparam int DATA_DEPTH_DEF = 32;
	localparam int CTRL_DEPTH_DEF = 32;
	localparam int CELL_WIDTH_DEF = 32;

	localparam int MODE_W  = 5;
	localparam int VALUE_W = 32;
	localparam int DEPTH_W = 6;
	localparam int FAULT_W = 3;

	typedef enum logic [MODE_W-1:0] {
		M_ADD      = 5'd0,
		M_SUB      = 5'd1,
		M_DIV      = 5'd2,
		M_MUL      = 5'd3,
		M_MOD      = 5'd4,
		M_DIVMOD   = 5'd5,
		M_SWAP     = 5'd6,
		M_CSWAP    = 5'd7,
		M_DUP      = 5'd8,
		M_CDUP     = 5'd9,
		M_ROT      = 5'd10,
		M_CROT     = 5'd11,
		M_DROP     = 5'd12,
		M_CDROP    = 5'd13,
		M_AND      = 5'd14,
		M_OR       = 5'd15,
		M_GT       = 5'd16,
		M_EQ       = 5'd17,
		M_LT       = 5'd18,
		M_GE       = 5'd19,
		M_LE       = 5'd20,
		M_BAND     = 5'd21,
		M_BOR      = 5'd22,
		M_OVER     = 5'd23,
		M_PRINT    = 5'd24,
		M_I        = 5'd25,
		M_J        = 5'd26,
		M_TO_CTRL  = 5'd27,
		M_TO_DATA  = 5'd28,
		M_LIT      = 5'd29
	} mode_t;

	typedef enum logic [FAULT_W-1:0] {
		F_OK     = 3'd0,
		F_DIV0   = 3'd1,
		F_DUNDER = 3'd2,
		F_CUNDER = 3'd3,
		F_DOVER  = 3'd4,
		F_COVER  = 3'd5
	} fault_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_PUSH,
		SH_POP
	} shift_t;

	typedef struct packed {
		shift_t     shift;
		logic [2:0] load;
	} stk_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIVW,
		S_DONE
	} state_t;

endpackage

// File: hw/rtl/fsa_if.sv
interface fsa_cmd_if;
	import fsa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [MODE_W-1:0]         mode;
	logic signed [VALUE_W-1:0] literal;
	modport source (output valid, mode, literal, input ready);
	modport sink (input valid, mode, literal, output ready);
endinterface

interface fsa_rsp_if;
	import fsa_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] top_value;
	logic [DEPTH_W-1:0]        data_depth;
	logic [DEPTH_W-1:0]        ctrl_depth;
	logic [FAULT_W-1:0]        fault_code;
	logic                      print_valid;
	logic signed [VALUE_W-1:0] print_value;
	logic                      print_empty;
	modport source (output valid, top_value, data_depth, ctrl_depth, fault_code,
		print_valid, print_value, print_empty, input ready);
	modport sink (input valid, top_value, data_depth, ctrl_depth, fault_code,
		print_valid, print_value, print_empty, output ready);
endinterface

// File: hw/rtl/fsa_cell.sv
module fsa_cell #(
	parameter int W = fsa_pkg::CELL_WIDTH_DEF
) (
	input  logic            clk,
	input  fsa_pkg::shift_t shift,
	input  logic            load,
	input  logic [W-1:0]    load_val,
	input  logic [W-1:0]    above,
	input  logic [W-1:0]    below,
	output logic [W-1:0]    val
);
	import fsa_pkg::*;

	logic [W-1:0] val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else begin
			unique case (shift)
				SH_PUSH: val_q <= above;
				SH_POP:  val_q <= below;
				default: val_q <= val_q;
			endcase
		end
	end

	assign val = val_q;
endmodule

// File: hw/rtl/fsa_stack.sv
module fsa_stack #(
	parameter int DEPTH = fsa_pkg::DATA_DEPTH_DEF,
	parameter int W     = fsa_pkg::CELL_WIDTH_DEF
) (
	input  logic              clk,
	input  fsa_pkg::stk_cmd_t cmd,
	input  logic [2:0][W-1:0] load_val,
	output logic [3:0][W-1:0] top
);
	import fsa_pkg::*;

	logic [W-1:0] cell_val [DEPTH];

	// cell 0 is the top of the stack, a push moves every entry one cell down
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] above;
		logic [W-1:0] below;
		logic         ld;
		logic [W-1:0] ldv;
		if (i == 0) begin : g_first
			assign above = '0;
		end else begin : g_mid
			assign above = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_nlast
			assign below = cell_val[i+1];
		end
		if (i < 3) begin : g_ld
			assign ld  = cmd.load[i];
			assign ldv = load_val[i];
		end else begin : g_nld
			assign ld  = 1'b0;
			assign ldv = '0;
		end
		fsa_cell #(.W(W)) u_cell (
			.clk      (clk),
			.shift    (cmd.shift),
			.load     (ld),
			.load_val (ldv),
			.above    (above),
			.below    (below),
			.val      (cell_val[i])
		);
	end

	assign top[0] = cell_val[0];
	assign top[1] = cell_val[1];
	assign top[2] = cell_val[2];
	assign top[3] = cell_val[3];
endmodule

// File: hw/rtl/fsa_div.sv
module fsa_div #(
	parameter int W = fsa_pkg::CELL_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	import fsa_pkg::*;

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             nq_q;
	logic             nr_q;
	logic [W:0]       shifted;
	logic [W:0]       diff;

	// one quotient bit per cycle on magnitudes, signs fixed at the end
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (-dividend) : dividend;
			dvs_q <= divisor[W-1] ? (-divisor) : divisor;
			nq_q  <= dividend[W-1] ^ divisor[W-1];
			nr_q  <= dividend[W-1];
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = nq_q ? (-quo_q) : quo_q;
	assign remainder = nr_q ? (-rem_q) : rem_q;
endmodule

// File: hw/rtl/forth_two_stack_alu.sv
// Forth primitive engine with a data stack and a control stack, each a row of
// cells with the top entry in the first cell; every primitive shifts the row
// by at most one place and rewrites at most its top three cells. One request
// is worked at a time; div, mod and divmod wait on the radix-2 divider that
// produces one quotient bit per cycle. A new request is accepted once the
// previous one has left the execute path, even while its result still waits
// to be taken. On a fault neither stack nor depth changes.
module forth_two_stack_alu #(
	parameter int DATA_DEPTH = fsa_pkg::DATA_DEPTH_DEF,
	parameter int CTRL_DEPTH = fsa_pkg::CTRL_DEPTH_DEF,
	parameter int CELL_WIDTH = fsa_pkg::CELL_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fsa_cmd_if.sink   cmd,
	fsa_rsp_if.source rsp
);
	import fsa_pkg::*;

	localparam int W   = CELL_WIDTH;
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int CCW = $clog2(CTRL_DEPTH + 1);

	state_t            state_q, state_d;
	mode_t             mode_q;
	logic [W-1:0]      lit_q;
	logic [DCW-1:0]    dcnt_q;
	logic [CCW-1:0]    ccnt_q;
	logic [W-1:0]      e1_q, e3_q;
	fault_t            fault_q;
	logic              pvalid_q, pempty_q;
	logic [VALUE_W-1:0] pvalue_q;
	logic              rsp_valid_q;
	logic [VALUE_W-1:0] top_q, prv_q;
	logic [DEPTH_W-1:0] dd_q, cd_q;
	logic [FAULT_W-1:0] fc_q;
	logic              pv_q, pe_q;

	logic [3:0][W-1:0] ds, cs;
	logic [2:0][W-1:0] dv, cv;
	stk_cmd_t          dcmd, ccmd;
	logic              div_start, div_done;
	logic [W-1:0]      div_q, div_r;
	logic signed [63:0] lit64;
	logic [W-1:0]      lit_cell;

	fault_t            fault;
	logic              is_div, is_bin;
	logic [W-1:0]      bin_res;
	logic [W-1:0]      prod;
	logic              d_full, c_full;
	logic              commit;
	logic [DCW-1:0]    dcnt_d;
	logic [CCW-1:0]    ccnt_d;
	logic [2:0][W-1:0] cpost;
	logic [63:0]       top64, pr64;

	assign lit64    = 64'(cmd.literal);
	assign lit_cell = lit64[W-1:0];

	fsa_stack #(.DEPTH(DATA_DEPTH), .W(W)) u_dstk (
		.clk(clk), .cmd(dcmd), .load_val(dv), .top(ds)
	);
	fsa_stack #(.DEPTH(CTRL_DEPTH), .W(W)) u_cstk (
		.clk(clk), .cmd(ccmd), .load_val(cv), .top(cs)
	);
	fsa_div #(.W(W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(ds[1]),
		.divisor(ds[0]), .done(div_done), .quotient(div_q), .remainder(div_r)
	);

	assign d_full = (dcnt_q == DCW'(DATA_DEPTH));
	assign c_full = (ccnt_q == CCW'(CTRL_DEPTH));
	assign is_div = (mode_q == M_DIV) || (mode_q == M_MOD) || (mode_q == M_DIVMOD);
	assign prod   = ds[0] * ds[1];

	always_comb begin
		is_bin  = 1'b0;
		bin_res = '0;
		unique case (mode_q)
			M_ADD:  begin is_bin = 1'b1; bin_res = ds[1] + ds[0]; end
			M_SUB:  begin is_bin = 1'b1; bin_res = ds[1] - ds[0]; end
			M_MUL:  begin is_bin = 1'b1; bin_res = prod; end
			M_DIV, M_MOD, M_DIVMOD: is_bin = 1'b1;
			M_AND:  begin is_bin = 1'b1; bin_res = W'((ds[0] != '0) && (ds[1] != '0)); end
			M_OR:   begin is_bin = 1'b1; bin_res = W'((ds[0] != '0) || (ds[1] != '0)); end
			M_GT:   begin is_bin = 1'b1; bin_res = W'($signed(ds[1]) < $signed(ds[0])); end
			M_EQ:   begin is_bin = 1'b1; bin_res = W'(ds[0] == ds[1]); end
			M_LT:   begin is_bin = 1'b1; bin_res = W'($signed(ds[0]) < $signed(ds[1])); end
			M_GE:   begin is_bin = 1'b1; bin_res = W'(!($signed(ds[0]) < $signed(ds[1]))); end
			M_LE:   begin is_bin = 1'b1; bin_res = W'(!($signed(ds[1]) < $signed(ds[0]))); end
			M_BAND: begin is_bin = 1'b1; bin_res = W'((ds[0] & ds[1]) != '0); end
			M_BOR:  begin is_bin = 1'b1; bin_res = W'((ds[0] | ds[1]) != '0); end
			default: ;
		endcase
	end

	// fault check, ordered underflow before overflow
	always_comb begin
		fault = F_OK;
		if (is_bin) begin
			if (dcnt_q < DCW'(2)) fault = F_DUNDER;
			else if (is_div && ds[0] == '0) fault = F_DIV0;
		end else begin
			unique case (mode_q)
				M_SWAP:  if (dcnt_q < DCW'(2)) fault = F_DUNDER;
				M_CSWAP: if (ccnt_q < CCW'(2)) fault = F_CUNDER;
				M_DUP:
					if (dcnt_q < DCW'(1)) fault = F_DUNDER;
					else if (d_full) fault = F_DOVER;
				M_CDUP:
					if (ccnt_q < CCW'(1)) fault = F_CUNDER;
					else if (c_full) fault = F_COVER;
				M_ROT:   if (dcnt_q < DCW'(3)) fault = F_DUNDER;
				M_CROT:  if (ccnt_q < CCW'(3)) fault = F_CUNDER;
				M_DROP:  if (dcnt_q < DCW'(1)) fault = F_DUNDER;
				M_CDROP: if (ccnt_q < CCW'(1)) fault = F_CUNDER;
				M_OVER:
					if (dcnt_q < DCW'(2)) fault = F_DUNDER;
					else if (d_full) fault = F_DOVER;
				M_I:
					if (ccnt_q < CCW'(2)) fault = F_CUNDER;
					else if (d_full) fault = F_DOVER;
				M_J:
					if (ccnt_q < CCW'(4)) fault = F_CUNDER;
					else if (d_full) fault = F_DOVER;
				M_TO_CTRL:
					if (dcnt_q < DCW'(1)) fault = F_DUNDER;
					else if (c_full) fault = F_COVER;
				M_TO_DATA:
					if (ccnt_q < CCW'(1)) fault = F_CUNDER;
					else if (d_full) fault = F_DOVER;
				M_LIT:   if (d_full) fault = F_DOVER;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (cmd.valid) state_d = S_EXEC;
			S_EXEC: state_d = (is_div && fault == F_OK) ? S_DIVW : S_DONE;
			S_DIVW: if (div_done) state_d = S_DONE;
			S_DONE: if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// stack commands
	always_comb begin
		dcmd      = '{shift: SH_HOLD, load: 3'b000};
		ccmd      = '{shift: SH_HOLD, load: 3'b000};
		dv        = '0;
		cv        = '0;
		div_start = 1'b0;
		commit    = 1'b0;
		if (state_q == S_EXEC && fault == F_OK) begin
			commit = 1'b1;
			if (is_div) begin
				div_start = 1'b1;
				commit    = 1'b0;
			end else if (is_bin) begin
				dcmd = '{shift: SH_POP, load: 3'b001};
				dv[0] = bin_res;
			end else begin
				unique case (mode_q)
					M_SWAP: begin
						dcmd = '{shift: SH_HOLD, load: 3'b011};
						dv[0] = ds[1]; dv[1] = ds[0];
					end
					M_CSWAP: begin
						ccmd = '{shift: SH_HOLD, load: 3'b011};
						cv[0] = cs[1]; cv[1] = cs[0];
					end
					M_DUP: begin
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = ds[0];
					end
					M_CDUP: begin
						ccmd = '{shift: SH_PUSH, load: 3'b001};
						cv[0] = cs[0];
					end
					M_ROT: begin
						dcmd = '{shift: SH_HOLD, load: 3'b111};
						dv[0] = ds[2]; dv[1] = ds[0]; dv[2] = ds[1];
					end
					M_CROT: begin
						ccmd = '{shift: SH_HOLD, load: 3'b111};
						cv[0] = cs[2]; cv[1] = cs[0]; cv[2] = cs[1];
					end
					M_DROP, M_PRINT: begin
						if (dcnt_q != '0) dcmd = '{shift: SH_POP, load: 3'b000};
					end
					M_CDROP: ccmd = '{shift: SH_POP, load: 3'b000};
					M_OVER: begin
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = ds[1];
					end
					M_I: begin
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = e1_q;
					end
					M_J: begin
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = e3_q;
					end
					M_TO_CTRL: begin
						dcmd = '{shift: SH_POP, load: 3'b000};
						ccmd = '{shift: SH_PUSH, load: 3'b001};
						cv[0] = ds[0];
					end
					M_TO_DATA: begin
						ccmd = '{shift: SH_POP, load: 3'b000};
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = cs[0];
					end
					M_LIT: begin
						dcmd = '{shift: SH_PUSH, load: 3'b001};
						dv[0] = lit_q;
					end
					default: ;
				endcase
			end
		end else if (state_q == S_DIVW && div_done) begin
			unique case (mode_q)
				M_DIV: begin
					dcmd = '{shift: SH_POP, load: 3'b001};
					dv[0] = div_q;
				end
				M_MOD: begin
					dcmd = '{shift: SH_POP, load: 3'b001};
					dv[0] = div_r;
				end
				default: begin
					dcmd = '{shift: SH_HOLD, load: 3'b011};
					dv[0] = div_r; dv[1] = div_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (dcmd.shift)
			SH_PUSH: dcnt_d = dcnt_q + 1'b1;
			SH_POP:  dcnt_d = dcnt_q - 1'b1;
			default: dcnt_d = dcnt_q;
		endcase
		unique case (ccmd.shift)
			SH_PUSH: ccnt_d = ccnt_q + 1'b1;
			SH_POP:  ccnt_d = ccnt_q - 1'b1;
			default: ccnt_d = ccnt_q;
		endcase
	end

	// control top three after the step, used to track entries 1 and 3 from bottom
	for (genvar k = 0; k < 3; k++) begin : g_cpost
		always_comb begin
			if (ccmd.load[k]) begin
				cpost[k] = cv[k];
			end else begin
				unique case (ccmd.shift)
					SH_PUSH: cpost[k] = (k == 0) ? '0 : cs[(k == 0) ? 0 : k-1];
					SH_POP:  cpost[k] = cs[k+1];
					default: cpost[k] = cs[k];
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dcnt_q      <= '0;
			ccnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			dcnt_q  <= dcnt_d;
			ccnt_q  <= ccnt_d;
			if (state_q == S_DONE && state_d == S_IDLE) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	assign top64 = 64'($signed(ds[0]));

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd.valid) begin
			mode_q <= mode_t'(cmd.mode);
			lit_q  <= lit_cell;
		end
		if (commit) begin
			for (int k = 0; k < 3; k++) begin
				if (ccnt_d == CCW'(k + 2)) e1_q <= cpost[k];
				if (ccnt_d == CCW'(k + 4)) e3_q <= cpost[k];
			end
		end
		if (state_q == S_EXEC) begin
			fault_q  <= fault;
			pvalid_q <= (mode_q == M_PRINT) && (dcnt_q != '0);
			pempty_q <= (mode_q == M_PRINT) && (dcnt_q == '0);
			pvalue_q <= ((mode_q == M_PRINT) && (dcnt_q != '0)) ? top64[VALUE_W-1:0] : '0;
		end
		if (state_q == S_DONE && state_d == S_IDLE) begin
			top_q <= (dcnt_q != '0) ? top64[VALUE_W-1:0] : '0;
			dd_q  <= DEPTH_W'(dcnt_q);
			cd_q  <= DEPTH_W'(ccnt_q);
			fc_q  <= fault_q;
			pv_q  <= pvalid_q;
			prv_q <= pvalue_q;
			pe_q  <= pempty_q;
		end
	end

	assign pr64 = 64'(prv_q);

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.top_value   = top_q;
	assign rsp.data_depth  = dd_q;
	assign rsp.ctrl_depth  = cd_q;
	assign rsp.fault_code  = fc_q;
	assign rsp.print_valid = pv_q;
	assign rsp.print_value = pr64[VALUE_W-1:0];
	assign rsp.print_empty = pe_q;

	a_dcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q <= DCW'(DATA_DEPTH))
		else $error("data count beyond depth");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW)
		else $error("divider finished outside divide wait");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && fault != F_OK) |=>
			($stable(dcnt_q) && $stable(ccnt_q)))
		else $error("stack depth changed on a faulting request");
endmodule
